// ===== rtl/core/fdc_pkg.sv =====
package fdc_pkg;

    // payload buffer depth and derived widths
    localparam int PAYLOAD_MAX = 32;
    localparam int ADDR_W      = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
    localparam int CNT_W       = $clog2(PAYLOAD_MAX + 1);
    localparam int POS_W       = $clog2(PAYLOAD_MAX + 13);
    // position compares: length byte plus header/trailer offsets
    localparam int CMP_W       = 9;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_START_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION      = 2'd2;

    // result status codes
    localparam logic [2:0] STATUS_OK    = 3'd0;
    localparam logic [2:0] STATUS_LEN   = 3'd1;
    localparam logic [2:0] STATUS_START = 3'd2;
    localparam logic [2:0] STATUS_VER   = 3'd3;
    localparam logic [2:0] STATUS_CRC   = 3'd4;

    typedef struct packed {
        logic [7:0] raw_byte;
        logic       buffer_end;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  source_id;
        logic [7:0]  dest_id;
        logic [7:0]  command;
        logic [15:0] sequence_res;
        logic [5:0]  payload_length;
        logic [7:0]  frame_flags;
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic        last_of_run;
    } t_result;

    // controller to datapath
    typedef struct packed {
        logic take_byte;
        logic emit_burst;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_busy;
        logic burst_go;
        logic burst_last;
    } t_dp_status;

endpackage

// ===== rtl/core/fdc_byte_if.sv =====
interface fdc_byte_if;
    import fdc_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/fdc_result_if.sv =====
interface fdc_result_if;
    import fdc_pkg::*;

    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/fdc_ram.sv =====
module fdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ===== rtl/core/fdc_ctrl.sv =====
module fdc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  fdc_pkg::t_dp_status i_status,
    output logic                o_in_ready,
    output fdc_pkg::t_dp_cmd    o_cmd
);
    import fdc_pkg::*;

    localparam logic ST_RUN   = 1'b0;
    localparam logic ST_BURST = 1'b1;

    logic r_state;
    logic n_state;
    logic in_ready;

    assign in_ready         = (r_state == ST_RUN) && !i_status.out_busy;
    assign o_in_ready       = in_ready;
    assign o_cmd.take_byte  = i_in_valid && in_ready;
    assign o_cmd.emit_burst = (r_state == ST_BURST) && !i_status.out_busy;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_RUN: begin
                if (o_cmd.take_byte && i_status.burst_go) begin
                    n_state = ST_BURST;
                end
            end
            ST_BURST: begin
                if (o_cmd.emit_burst && i_status.burst_last) begin
                    n_state = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ===== rtl/core/fdc_datapath.sv =====
module fdc_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  fdc_pkg::t_in_item            i_item,
    input  fdc_pkg::t_dp_cmd             i_cmd,
    output fdc_pkg::t_dp_status          o_status,
    input  logic                         i_cfg_wr_en,
    input  logic [fdc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fdc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output fdc_pkg::t_result             o_out_data
);
    import fdc_pkg::*;

    localparam logic [POS_W-1:0] POS_START0  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_START1  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_VERSION = POS_W'(2);
    localparam logic [POS_W-1:0] POS_SOURCE  = POS_W'(3);
    localparam logic [POS_W-1:0] POS_DEST    = POS_W'(4);
    localparam logic [POS_W-1:0] POS_CMD     = POS_W'(5);
    localparam logic [POS_W-1:0] POS_SEQ_HI  = POS_W'(6);
    localparam logic [POS_W-1:0] POS_SEQ_LO  = POS_W'(7);
    localparam logic [POS_W-1:0] POS_LENGTH  = POS_W'(8);
    localparam logic [POS_W-1:0] POS_VERDICT = POS_W'(11);
    localparam logic [CMP_W-1:0] OFS_PAYLOAD = CMP_W'(9);
    localparam logic [CMP_W-1:0] OFS_FLAGS   = CMP_W'(9);
    localparam logic [CMP_W-1:0] OFS_CRC_HI  = CMP_W'(10);
    localparam logic [CMP_W-1:0] OFS_CRC_LO  = CMP_W'(11);
    localparam logic [15:0]      CRC_INIT    = 16'hFFFF;
    localparam logic [15:0]      CRC_POLY    = 16'h1021;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    // configuration
    logic [7:0] r_start_first;
    logic [7:0] r_start_second;
    logic [7:0] r_version;

    // frame control state
    logic [POS_W-1:0] r_pos,  n_pos;
    logic [15:0]      r_crc,  n_crc;
    logic [2:0]       r_perr, n_perr;
    logic             r_skip, n_skip;

    // frame fields
    logic [7:0]  r_src, r_dst, r_cmd, r_len, r_flags, r_crc_hi;
    logic [15:0] r_seq;

    // burst and output
    logic [CNT_W-1:0] r_bidx;
    logic             r_out_valid;
    t_result          r_out;
    t_result          n_out;
    logic             load_out;

    logic [7:0]        b;
    logic              buf_end;
    logic [CMP_W-1:0]  p_ext;
    logic [CMP_W-1:0]  len_ext;
    logic [CMP_W-1:0]  wr_ofs;
    logic [CMP_W-1:0]  bidx_next;
    logic [15:0]       crc_upd;
    logic              complete;
    logic              crc_ok;
    logic              verdict;
    logic              good_burst;
    logic              ram_wr_en;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [7:0]        ram_rd_data;
    logic              hdr_wr;
    logic              flags_wr;
    logic              crc_hi_wr;

    assign b         = i_item.raw_byte;
    assign buf_end   = i_item.buffer_end;
    assign p_ext     = CMP_W'(r_pos);
    assign len_ext   = CMP_W'(r_len);
    assign wr_ofs    = p_ext - OFS_PAYLOAD;
    assign crc_upd   = crc_byte(r_crc, b);
    assign bidx_next = CMP_W'(r_bidx) + CMP_W'(1);

    always_comb begin
        n_pos     = r_pos;
        n_crc     = r_crc;
        n_perr    = r_perr;
        n_skip    = r_skip;
        complete  = 1'b0;
        ram_wr_en = 1'b0;
        hdr_wr    = 1'b0;
        flags_wr  = 1'b0;
        crc_hi_wr = 1'b0;
        if (!r_skip) begin
            if (r_pos == POS_START0) begin
                if (b != r_start_first && r_perr == STATUS_OK) begin
                    n_perr = STATUS_START;
                end
            end else if (r_pos == POS_START1) begin
                if (b != r_start_second && r_perr == STATUS_OK) begin
                    n_perr = STATUS_START;
                end
            end else if (r_pos == POS_VERSION) begin
                if (b != r_version && r_perr == STATUS_OK) begin
                    n_perr = STATUS_VER;
                end
                n_crc = crc_upd;
            end else if (r_pos <= POS_LENGTH) begin
                hdr_wr = 1'b1;
                n_crc  = crc_upd;
                if (r_pos == POS_LENGTH && b > 8'(PAYLOAD_MAX) && r_perr == STATUS_OK) begin
                    n_perr = STATUS_LEN;
                end
            end else if (r_perr == STATUS_OK) begin
                if (p_ext < len_ext + OFS_PAYLOAD) begin
                    ram_wr_en = 1'b1;
                    n_crc     = crc_upd;
                end else if (p_ext == len_ext + OFS_FLAGS) begin
                    flags_wr = 1'b1;
                    n_crc    = crc_upd;
                end else if (p_ext == len_ext + OFS_CRC_HI) begin
                    crc_hi_wr = 1'b1;
                end else if (p_ext == len_ext + OFS_CRC_LO) begin
                    complete = 1'b1;
                end
            end
            n_pos = r_pos + POS_W'(1);
        end
        crc_ok     = ({r_crc_hi, b} == r_crc);
        verdict    = !r_skip && (complete || (r_pos == POS_VERDICT && r_perr != STATUS_OK)
                     || buf_end);
        good_burst = !r_skip && complete && crc_ok && (r_len != 8'd0);
        if (buf_end) begin
            n_pos  = '0;
            n_crc  = CRC_INIT;
            n_perr = STATUS_OK;
            n_skip = 1'b0;
        end else if (verdict) begin
            n_skip = 1'b1;
        end
    end

    // next result
    always_comb begin
        n_out               = '0;
        n_out.last_of_run   = 1'b1;
        load_out            = 1'b0;
        if (i_cmd.emit_burst) begin
            load_out             = 1'b1;
            n_out.status         = STATUS_OK;
            n_out.source_id      = r_src;
            n_out.dest_id        = r_dst;
            n_out.command        = r_cmd;
            n_out.sequence_res   = r_seq;
            n_out.payload_length = r_len[5:0];
            n_out.frame_flags    = r_flags;
            n_out.payload_byte   = ram_rd_data;
            n_out.payload_valid  = 1'b1;
            n_out.last_of_run    = (bidx_next == len_ext);
        end else if (i_cmd.take_byte && verdict && !good_burst) begin
            load_out = 1'b1;
            if (complete && !crc_ok) begin
                n_out.status = STATUS_CRC;
            end else if (complete) begin
                // empty payload: header only
                n_out.status         = STATUS_OK;
                n_out.source_id      = r_src;
                n_out.dest_id        = r_dst;
                n_out.command        = r_cmd;
                n_out.sequence_res   = r_seq;
                n_out.payload_length = r_len[5:0];
                n_out.frame_flags    = r_flags;
            end else if (r_pos == POS_VERDICT && r_perr != STATUS_OK) begin
                n_out.status = r_perr;
            end else begin
                n_out.status = STATUS_LEN;
            end
        end
    end

    assign ram_rd_en   = (i_cmd.take_byte && good_burst) || i_cmd.emit_burst;
    assign ram_rd_addr = i_cmd.emit_burst ? bidx_next[ADDR_W-1:0] : '0;

    fdc_ram #(
        .WIDTH (8),
        .DEPTH (PAYLOAD_MAX)
    ) u_payload_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.take_byte && ram_wr_en),
        .i_wr_addr (wr_ofs[ADDR_W-1:0]),
        .i_wr_data (b),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_first  <= 8'hAA;
            r_start_second <= 8'h55;
            r_version      <= 8'h01;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_START_FIRST:  r_start_first  <= i_cfg_wdata;
                CFG_START_SECOND: r_start_second <= i_cfg_wdata;
                CFG_VERSION:      r_version      <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_crc       <= CRC_INIT;
            r_perr      <= STATUS_OK;
            r_skip      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.take_byte) begin
                r_pos  <= n_pos;
                r_crc  <= n_crc;
                r_perr <= n_perr;
                r_skip <= n_skip;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_byte && hdr_wr) begin
            case (r_pos)
                POS_SOURCE: r_src        <= b;
                POS_DEST:   r_dst        <= b;
                POS_CMD:    r_cmd        <= b;
                POS_SEQ_HI: r_seq[15:8]  <= b;
                POS_SEQ_LO: r_seq[7:0]   <= b;
                POS_LENGTH: r_len        <= b;
                default: ;
            endcase
        end
        if (i_cmd.take_byte && flags_wr) begin
            r_flags <= b;
        end
        if (i_cmd.take_byte && crc_hi_wr) begin
            r_crc_hi <= b;
        end
        if (i_cmd.take_byte && good_burst) begin
            r_bidx <= '0;
        end else if (i_cmd.emit_burst) begin
            r_bidx <= bidx_next[CNT_W-1:0];
        end
        if (load_out) begin
            r_out <= n_out;
        end
    end

    assign o_status.out_busy   = r_out_valid && !i_out_ready;
    assign o_status.burst_go   = good_burst;
    assign o_status.burst_last = (bidx_next == len_ext);
    assign o_out_valid         = r_out_valid;
    assign o_out_data          = r_out;
endmodule

// ===== rtl/core/frame_deframer_crc16.sv =====
// byte-serial frame parser: takes one buffer byte per transfer (buffer_end on the last
// byte), checks start bytes, version, length and a crc-16/ccitt-false over version through
// flags, and gives one verdict per buffer. a byte is taken every cycle while the output
// register is free; errors and empty-payload frames give one result, registered from the
// deciding byte. a good frame with n payload bytes gives n results, one per cycle while
// not stalled, read back from a payload ram with registered read; the input is stalled
// while they are sent (n up to PAYLOAD_MAX). bytes after the verdict are dropped up to
// the buffer end, and the byte with buffer_end always restarts the parser. configuration
// writes go to the start-byte and version registers and are meant for idle time only.
module frame_deframer_crc16 (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    fdc_byte_if.sink                       i_in,
    fdc_result_if.source                   o_out,
    input  logic                           i_cfg_wr_en,
    input  logic [fdc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fdc_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import fdc_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    logic       in_ready;

    // controller: input ready and burst sequencing
    fdc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (dp_status),
        .o_in_ready (in_ready),
        .o_cmd      (dp_cmd)
    );

    // datapath: field capture, crc, payload ram and output register
    fdc_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_in.data),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_data  (o_out.data)
    );

    assign i_in.ready = in_ready;
endmodule
